### rtl/core/grid_wavefront_distance_planner_assert.svh
// Assertion helpers shared by the planner RTL.
`ifndef GRID_WAVEFRONT_DISTANCE_PLANNER_ASSERT_SVH
`define GRID_WAVEFRONT_DISTANCE_PLANNER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GWDP_ASSERT_SAME(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GWDP_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/gwdp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package gwdp_pkg;

    localparam int DIST_W  = 24;
    localparam int ENTRY_W = 26;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 7;
    localparam longint SQRT2_Q30 = 64'd1518500250;
    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CONT  = 3'd3;

    typedef enum logic [1:0] {
        CMD_LOAD = 2'd0,
        CMD_DIST = 2'd1,
        CMD_NEXT = 2'd2,
        CMD_NONE = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_UNSET  = 2'd0,
        ST_VAL    = 2'd1,
        ST_OBST   = 2'd2,
        ST_NOPATH = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        MODE_WAVE,
        MODE_RELAX,
        MODE_QUERY
    } t_mode;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_GOAL_RD,
        S_GOAL_CHK,
        S_INIT_RD,
        S_INIT_WR,
        S_GOAL_WR,
        S_CTR_RD,
        S_CTR_CHK,
        S_SCAN,
        S_UPD,
        S_NP_RD,
        S_NP_CHK
    } t_state;

    typedef struct packed {
        logic clr;
        logic smp;
    } t_best_ctl;

    // Row offset (0..2 meaning -1..+1) of a 3x3 window position in raster order.
    function automatic logic [1:0] win_dr(input logic [3:0] k);
        logic [1:0] d;
        case (k)
            4'd0, 4'd1, 4'd2: d = 2'd0;
            4'd3, 4'd4, 4'd5: d = 2'd1;
            default:          d = 2'd2;
        endcase
        return d;
    endfunction

    function automatic logic [1:0] win_dc(input logic [3:0] k);
        logic [1:0] d;
        case (k)
            4'd0, 4'd3, 4'd6: d = 2'd0;
            4'd1, 4'd4, 4'd7: d = 2'd1;
            default:          d = 2'd2;
        endcase
        return d;
    endfunction

endpackage
`default_nettype wire

### rtl/core/gwdp_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module gwdp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

### rtl/core/gwdp_best_unit.sv
`timescale 1ns / 1ps
`default_nettype none
module gwdp_best_unit #(
    parameter int RW = 6,
    parameter int CW = 6,
    parameter int FRAC_BITS = 8
) (
    input  wire logic                      i_clk,
    input  wire gwdp_pkg::t_best_ctl       i_ctl,
    input  wire logic [gwdp_pkg::DIST_W-1:0] i_value,
    input  wire logic                      i_diag,
    input  wire logic [RW-1:0]             i_row,
    input  wire logic [CW-1:0]             i_col,
    input  wire logic                      i_continuous,
    output logic                           o_found,
    output logic [gwdp_pkg::DIST_W-1:0]    o_best,
    output logic [RW-1:0]                  o_best_row,
    output logic [CW-1:0]                  o_best_col,
    output logic [gwdp_pkg::DIST_W-1:0]    o_cand
);
    import gwdp_pkg::*;

    localparam longint StepOne  = 64'd1 << FRAC_BITS;
    localparam longint StepDiag = (SQRT2_Q30 + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);

    logic                r_found;
    logic [DIST_W-1:0]   r_best;
    logic                r_diag;
    logic [RW-1:0]       r_row;
    logic [CW-1:0]       r_col;
    logic [DIST_W:0]     sum;
    logic [DIST_W:0]     step;

    always_ff @(posedge i_clk) begin
        if (i_ctl.clr) begin
            r_found <= 1'b0;
        end else if (i_ctl.smp && (!r_found || i_value < r_best)) begin
            r_found <= 1'b1;
            r_best  <= i_value;
            r_diag  <= i_diag;
            r_row   <= i_row;
            r_col   <= i_col;
        end
    end

    // Saturating add of one step to the best neighbour.
    always_comb begin
        step = (r_diag && i_continuous) ? (DIST_W+1)'(StepDiag) : (DIST_W+1)'(StepOne);
        sum  = {1'b0, r_best} + step;
        o_cand = sum[DIST_W] ? DIST_MAX : sum[DIST_W-1:0];
    end

    assign o_found    = r_found;
    assign o_best     = r_best;
    assign o_best_row = r_row;
    assign o_best_col = r_col;
endmodule
`default_nettype wire

### rtl/core/grid_wavefront_distance_planner.sv
`timescale 1ns / 1ps
`default_nettype none
// Grid wavefront distance planner.
// Command channel: an item is a transaction taken when start is high and busy is
// low. A load command writes one obstacle-map cell and finishes in that cycle
// with no result. Distance and next-step queries give one result, shown for
// exactly one cycle with o_result_valid; the receiver cannot stall it.
// Configuration: a write channel (i_cfg_valid, o_cfg_ready, index, data) that
// is always ready; it must only be used while the block is idle.
// Operation: a query whose goal matches the cached goal reads the start cell and
// then scans its 3x3 window. A goal change first rebuilds the distance map: an
// init sweep over every in-use cell, then wavefront or relaxation passes that
// skip some cells and visit the others, and passes repeat until nothing
// changes. The run time of a rebuild depends on how many wavefront passes the
// goal position needs, and on the window scan, which reads the distance memory
// one neighbour at a time.
// Reset: after reset the block clears all 2^(RW+CW) obstacle-map cells (4096 by
// default), with busy high; config writes are taken meanwhile.
module grid_wavefront_distance_planner #(
    parameter int MAX_ROWS  = 64,
    parameter int MAX_COLS  = 64,
    parameter int FRAC_BITS = 8
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic [1:0]                      i_cmd,
    input  wire logic [5:0]                      i_row,
    input  wire logic [5:0]                      i_col,
    input  wire logic [5:0]                      i_goal_row,
    input  wire logic [5:0]                      i_goal_col,
    input  wire logic                            i_obstacle,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [gwdp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [gwdp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                                 o_result_valid,
    output logic [23:0]                          o_dist_q8,
    output logic                                 o_no_path,
    output logic [5:0]                           o_next_row,
    output logic [5:0]                           o_next_col
);
    import gwdp_pkg::*;

    localparam int RW = $clog2(MAX_ROWS);
    localparam int CW = $clog2(MAX_COLS);
    localparam int AW = RW + CW;
    localparam int RowsReset = (64 > MAX_ROWS) ? MAX_ROWS : 64;
    localparam int ColsReset = (64 > MAX_COLS) ? MAX_COLS : 64;

    // Control and configuration registers.
    t_state r_state, n_state;
    t_mode  r_mode, n_mode;
    logic [CFG_DATA_W-1:0] r_rows, n_rows, r_cols, n_cols;
    logic r_eight, n_eight, r_cont, n_cont;
    logic r_cache_valid, n_cache_valid;
    logic [5:0] r_cg_r, n_cg_r, r_cg_c, n_cg_c;
    logic [AW-1:0] r_clr_addr, n_clr_addr;
    logic [RW-1:0] r_r, n_r, r_start_r, n_start_r, r_goal_r, n_goal_r;
    logic [CW-1:0] r_c, n_c, r_start_c, n_start_c, r_goal_c, n_goal_c;
    logic [5:0] r_start_r6, n_start_r6, r_start_c6, n_start_c6;
    logic [5:0] r_goal_r6, n_goal_r6, r_goal_c6, n_goal_c6;
    t_cmd r_cmd, n_cmd;
    logic [3:0] r_k, n_k;
    logic r_changed, n_changed, r_waiting, n_waiting, r_blocked, n_blocked;
    logic [DIST_W-1:0] r_ctr_val, n_ctr_val;
    logic r_p_valid, n_p_valid, r_p_diag, n_p_diag;
    logic [RW-1:0] r_p_r, n_p_r;
    logic [CW-1:0] r_p_c, n_p_c;
    logic r_res_valid, n_res_valid, r_res_np, n_res_np;
    logic [DIST_W-1:0] r_res_dist, n_res_dist;
    logic [5:0] r_res_nr, n_res_nr, r_res_nc, n_res_nc;

    // Memory ports.
    logic ob_we, ob_wdata, ob_rdata;
    logic [AW-1:0] ob_waddr, ob_raddr, ds_waddr, ds_raddr;
    logic ds_we;
    logic [ENTRY_W-1:0] ds_wdata, ds_rdata;

    // Best-neighbour unit.
    t_best_ctl best_ctl;
    logic best_found;
    logic [DIST_W-1:0] best_val, best_cand;
    logic [RW-1:0] best_r;
    logic [CW-1:0] best_c;

    // Window position and input conversions.
    logic [RW:0] nb_r;
    logic [CW:0] nb_c;
    logic [1:0] dr, dc;
    logic nb_diag, nb_ok, cell_last, accept, do_adv, do_finish, set_chg, set_wait;
    logic [RW+5:0] in_r_w, in_gr_w, br_w;
    logic [CW+5:0] in_c_w, in_gc_w, bc_w;
    logic [RW-1:0] in_r;
    logic [CW-1:0] in_c;
    t_status ds_st;
    logic [DIST_W-1:0] ds_val;
    logic query_in_grid, cache_hit;
    logic [CFG_DATA_W-1:0] cfg_clamp_r, cfg_clamp_c;

    gwdp_ram #(.WIDTH(1), .DEPTH(1 << AW)) u_obst_ram (
        .i_clk(i_clk), .i_we(ob_we), .i_waddr(ob_waddr), .i_wdata(ob_wdata),
        .i_raddr(ob_raddr), .o_rdata(ob_rdata)
    );

    gwdp_ram #(.WIDTH(ENTRY_W), .DEPTH(1 << AW)) u_dist_ram (
        .i_clk(i_clk), .i_we(ds_we), .i_waddr(ds_waddr), .i_wdata(ds_wdata),
        .i_raddr(ds_raddr), .o_rdata(ds_rdata)
    );

    gwdp_best_unit #(.RW(RW), .CW(CW), .FRAC_BITS(FRAC_BITS)) u_best (
        .i_clk(i_clk), .i_ctl(best_ctl), .i_value(ds_val), .i_diag(r_p_diag),
        .i_row(r_p_r), .i_col(r_p_c), .i_continuous(r_cont), .o_found(best_found),
        .o_best(best_val), .o_best_row(best_r), .o_best_col(best_c), .o_cand(best_cand)
    );

    always_comb begin
        in_r_w  = {{RW{1'b0}}, i_row};
        in_c_w  = {{CW{1'b0}}, i_col};
        in_gr_w = {{RW{1'b0}}, i_goal_row};
        in_gc_w = {{CW{1'b0}}, i_goal_col};
        br_w    = {6'd0, best_r};
        bc_w    = {6'd0, best_c};
        in_r    = in_r_w[RW-1:0];
        in_c    = in_c_w[CW-1:0];
        ds_st   = t_status'(ds_rdata[ENTRY_W-1:DIST_W]);
        ds_val  = ds_rdata[DIST_W-1:0];
        accept  = start && !busy;
        query_in_grid = (7'(i_row) < r_rows) && (7'(i_col) < r_cols)
                     && (7'(i_goal_row) < r_rows) && (7'(i_goal_col) < r_cols);
        cache_hit = r_cache_valid && (r_cg_r == i_goal_row) && (r_cg_c == i_goal_col);
        cell_last = (32'(r_c) == 32'(r_cols) - 1) && (32'(r_r) == 32'(r_rows) - 1);
        dr = win_dr(r_k);
        dc = win_dc(r_k);
        nb_r = (RW+1)'({1'b0, r_r} + (RW+1)'(dr) - (RW+1)'(1));
        nb_c = (CW+1)'({1'b0, r_c} + (CW+1)'(dc) - (CW+1)'(1));
        nb_diag = (dr != 2'd1) && (dc != 2'd1);
        nb_ok = (32'(nb_r) < 32'(r_rows)) && (32'(nb_c) < 32'(r_cols))
             && (r_eight || !nb_diag);
        cfg_clamp_r = (i_cfg_data == '0) ? CFG_DATA_W'(1)
                    : ((32'(i_cfg_data) > MAX_ROWS) ? CFG_DATA_W'(MAX_ROWS) : i_cfg_data);
        cfg_clamp_c = (i_cfg_data == '0) ? CFG_DATA_W'(1)
                    : ((32'(i_cfg_data) > MAX_COLS) ? CFG_DATA_W'(MAX_COLS) : i_cfg_data);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_mode        <= MODE_WAVE;
            r_rows        <= CFG_DATA_W'(RowsReset);
            r_cols        <= CFG_DATA_W'(ColsReset);
            r_eight       <= 1'b1;
            r_cont        <= 1'b0;
            r_cache_valid <= 1'b0;
            r_cg_r        <= '0;
            r_cg_c        <= '0;
            r_clr_addr    <= '0;
            r_res_valid   <= 1'b0;
            r_changed     <= 1'b0;
            r_waiting     <= 1'b0;
            r_k           <= '0;
        end else begin
            r_state       <= n_state;
            r_mode        <= n_mode;
            r_rows        <= n_rows;
            r_cols        <= n_cols;
            r_eight       <= n_eight;
            r_cont        <= n_cont;
            r_cache_valid <= n_cache_valid;
            r_cg_r        <= n_cg_r;
            r_cg_c        <= n_cg_c;
            r_clr_addr    <= n_clr_addr;
            r_res_valid   <= n_res_valid;
            r_changed     <= n_changed;
            r_waiting     <= n_waiting;
            r_k           <= n_k;
        end
        r_r        <= n_r;
        r_c        <= n_c;
        r_start_r  <= n_start_r;
        r_start_c  <= n_start_c;
        r_goal_r   <= n_goal_r;
        r_goal_c   <= n_goal_c;
        r_start_r6 <= n_start_r6;
        r_start_c6 <= n_start_c6;
        r_goal_r6  <= n_goal_r6;
        r_goal_c6  <= n_goal_c6;
        r_cmd      <= n_cmd;
        r_blocked  <= n_blocked;
        r_ctr_val  <= n_ctr_val;
        r_p_valid  <= n_p_valid;
        r_p_diag   <= n_p_diag;
        r_p_r      <= n_p_r;
        r_p_c      <= n_p_c;
        r_res_np   <= n_res_np;
        r_res_dist <= n_res_dist;
        r_res_nr   <= n_res_nr;
        r_res_nc   <= n_res_nc;
    end

    always_comb begin
        n_state = r_state;       n_mode = r_mode;
        n_rows = r_rows;         n_cols = r_cols;
        n_eight = r_eight;       n_cont = r_cont;
        n_cache_valid = r_cache_valid;
        n_cg_r = r_cg_r;         n_cg_c = r_cg_c;
        n_clr_addr = r_clr_addr;
        n_r = r_r;               n_c = r_c;
        n_start_r = r_start_r;   n_start_c = r_start_c;
        n_goal_r = r_goal_r;     n_goal_c = r_goal_c;
        n_start_r6 = r_start_r6; n_start_c6 = r_start_c6;
        n_goal_r6 = r_goal_r6;   n_goal_c6 = r_goal_c6;
        n_cmd = r_cmd;           n_k = r_k;
        n_changed = r_changed;   n_waiting = r_waiting;
        n_blocked = r_blocked;   n_ctr_val = r_ctr_val;
        n_p_valid = r_p_valid;   n_p_diag = r_p_diag;
        n_p_r = r_p_r;           n_p_c = r_p_c;
        n_res_valid = 1'b0;      n_res_np = r_res_np;
        n_res_dist = r_res_dist; n_res_nr = r_res_nr; n_res_nc = r_res_nc;
        ob_we = 1'b0;  ob_waddr = r_clr_addr;  ob_wdata = 1'b0;
        ob_raddr = {r_r, r_c};
        ds_we = 1'b0;  ds_waddr = {r_r, r_c};  ds_wdata = '0;
        ds_raddr = {r_r, r_c};
        best_ctl = '0;
        do_adv = 1'b0;  do_finish = 1'b0;
        set_chg = 1'b0; set_wait = 1'b0;

        // Register writes are to be made only while idle; the block itself does not enforce this and has no interlock.
        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ROWS:  begin n_rows = cfg_clamp_r;    n_cache_valid = 1'b0; end
                CFG_COLS:  begin n_cols = cfg_clamp_c;    n_cache_valid = 1'b0; end
                CFG_EIGHT: begin n_eight = i_cfg_data[0]; n_cache_valid = 1'b0; end
                CFG_CONT:  begin n_cont = i_cfg_data[0];  n_cache_valid = 1'b0; end
                default: ;
            endcase
        end

        case (r_state)
            S_CLEAR: begin
                ob_we = 1'b1;
                n_clr_addr = r_clr_addr + AW'(1);
                if (r_clr_addr == {AW{1'b1}}) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_cmd = t_cmd'(i_cmd);
                    n_start_r6 = i_row;
                    n_start_c6 = i_col;
                    n_goal_r6  = i_goal_row;
                    n_goal_c6  = i_goal_col;
                    n_start_r  = in_r;
                    n_start_c  = in_c;
                    n_goal_r   = in_gr_w[RW-1:0];
                    n_goal_c   = in_gc_w[CW-1:0];
                    case (t_cmd'(i_cmd))
                        CMD_LOAD: begin
                            if (32'(i_row) < MAX_ROWS && 32'(i_col) < MAX_COLS) begin
                                ob_we = 1'b1;
                                ob_waddr = {in_r, in_c};
                                ob_wdata = i_obstacle;
                                n_cache_valid = 1'b0;
                            end
                        end
                        CMD_DIST, CMD_NEXT: begin
                            if (!query_in_grid) begin
                                // Out-of-grid start or goal: answer at once.
                                n_res_valid = 1'b1;
                                n_res_np = 1'b1;
                                n_res_dist = '0;
                                n_res_nr = (t_cmd'(i_cmd) == CMD_NEXT) ? i_row : 6'd0;
                                n_res_nc = (t_cmd'(i_cmd) == CMD_NEXT) ? i_col : 6'd0;
                            end else if (cache_hit) begin
                                n_r = in_r;
                                n_c = in_c;
                                n_mode = MODE_QUERY;
                                n_state = S_CTR_RD;
                            end else begin
                                n_state = S_GOAL_RD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_GOAL_RD: begin
                ob_raddr = {r_goal_r, r_goal_c};
                n_state = S_GOAL_CHK;
            end
            S_GOAL_CHK: begin
                n_blocked = ob_rdata;
                n_r = '0;
                n_c = '0;
                n_state = S_INIT_RD;
            end
            S_INIT_RD: begin
                n_state = S_INIT_WR;
            end
            S_INIT_WR: begin
                ds_we = 1'b1;
                ds_wdata = {(r_blocked || ob_rdata) ? ST_OBST : ST_UNSET, {DIST_W{1'b0}}};
                do_adv = 1'b1;
            end
            S_GOAL_WR: begin
                ds_we = 1'b1;
                ds_waddr = {r_goal_r, r_goal_c};
                ds_wdata = {ST_VAL, {DIST_W{1'b0}}};
                n_mode = MODE_WAVE;
                n_state = S_CTR_RD;
            end
            S_CTR_RD: begin
                n_state = S_CTR_CHK;
            end
            S_CTR_CHK: begin
                n_ctr_val = ds_val;
                n_k = '0;
                case (r_mode)
                    MODE_WAVE: begin
                        if (ds_st == ST_UNSET) begin
                            best_ctl.clr = 1'b1;
                            n_state = S_SCAN;
                        end else begin
                            do_adv = 1'b1;
                        end
                    end
                    MODE_RELAX: begin
                        if (ds_st == ST_VAL) begin
                            best_ctl.clr = 1'b1;
                            n_state = S_SCAN;
                        end else begin
                            do_adv = 1'b1;
                        end
                    end
                    default: begin
                        if (ds_st == ST_VAL) begin
                            best_ctl.clr = 1'b1;
                            n_state = S_SCAN;
                        end else begin
                            n_res_valid = 1'b1;
                            n_res_np = 1'b1;
                            n_res_dist = '0;
                            n_res_nr = (r_cmd == CMD_NEXT) ? r_start_r6 : 6'd0;
                            n_res_nc = (r_cmd == CMD_NEXT) ? r_start_c6 : 6'd0;
                            n_state = S_IDLE;
                        end
                    end
                endcase
            end
            S_SCAN: begin
                // Issue the read of window position k; take the data of k-1.
                ds_raddr = {nb_r[RW-1:0], nb_c[CW-1:0]};
                n_p_valid = nb_ok && (r_k != 4'd9);
                n_p_diag = nb_diag;
                n_p_r = nb_r[RW-1:0];
                n_p_c = nb_c[CW-1:0];
                best_ctl.smp = (r_k != 4'd0) && r_p_valid && (ds_st == ST_VAL);
                if (r_k == 4'd9) begin
                    n_state = S_UPD;
                end else begin
                    n_k = r_k + 4'd1;
                end
            end
            S_UPD: begin
                case (r_mode)
                    MODE_WAVE: begin
                        if (best_found) begin
                            ds_we = 1'b1;
                            ds_wdata = {ST_VAL, best_cand};
                            set_chg = 1'b1;
                        end else begin
                            set_wait = 1'b1;
                        end
                        do_adv = 1'b1;
                    end
                    MODE_RELAX: begin
                        if (best_found && best_cand < r_ctr_val) begin
                            ds_we = 1'b1;
                            ds_wdata = {ST_VAL, best_cand};
                            set_chg = 1'b1;
                        end
                        do_adv = 1'b1;
                    end
                    default: begin
                        n_res_valid = 1'b1;
                        n_res_np = 1'b0;
                        n_res_dist = r_ctr_val;
                        if (r_cmd != CMD_NEXT) begin
                            n_res_nr = 6'd0;
                            n_res_nc = 6'd0;
                        end else if (best_found && best_val < r_ctr_val) begin
                            n_res_nr = br_w[5:0];
                            n_res_nc = bc_w[5:0];
                        end else begin
                            n_res_nr = r_start_r6;
                            n_res_nc = r_start_c6;
                        end
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_NP_RD: begin
                n_state = S_NP_CHK;
            end
            S_NP_CHK: begin
                if (ds_st == ST_UNSET) begin
                    ds_we = 1'b1;
                    ds_wdata = {ST_NOPATH, {DIST_W{1'b0}}};
                end
                do_adv = 1'b1;
            end
            default: n_state = S_IDLE;
        endcase

        n_changed = r_changed | set_chg;
        n_waiting = r_waiting | set_wait;

        if (do_adv) begin
            if (!cell_last) begin
                if (32'(r_c) == 32'(r_cols) - 1) begin
                    n_c = '0;
                    n_r = r_r + RW'(1);
                end else begin
                    n_c = r_c + CW'(1);
                end
                n_state = (r_state == S_INIT_WR) ? S_INIT_RD
                        : ((r_state == S_NP_CHK) ? S_NP_RD : S_CTR_RD);
            end else begin
                n_r = '0;
                n_c = '0;
                n_changed = 1'b0;
                n_waiting = 1'b0;
                if (r_state == S_INIT_WR) begin
                    if (r_blocked) begin
                        do_finish = 1'b1;
                    end else begin
                        n_state = S_GOAL_WR;
                    end
                end else if (r_state == S_NP_CHK) begin
                    n_mode = MODE_RELAX;
                    n_state = S_CTR_RD;
                end else if (r_mode == MODE_WAVE) begin
                    if (!(r_waiting | set_wait)) begin
                        n_mode = MODE_RELAX;
                        n_state = S_CTR_RD;
                    end else if (!(r_changed | set_chg)) begin
                        // A pass that changed nothing: the rest is unreachable.
                        n_state = S_NP_RD;
                    end else begin
                        n_state = S_CTR_RD;
                    end
                end else begin
                    if (r_changed | set_chg) begin
                        n_state = S_CTR_RD;
                    end else begin
                        do_finish = 1'b1;
                    end
                end
            end
        end

        if (do_finish) begin
            n_cache_valid = 1'b1;
            n_cg_r = r_goal_r6;
            n_cg_c = r_goal_c6;
            n_r = r_start_r;
            n_c = r_start_c;
            n_mode = MODE_QUERY;
            n_state = S_CTR_RD;
        end
    end

    assign busy           = (r_state != S_IDLE);
    assign o_cfg_ready    = 1'b1;
    assign o_result_valid = r_res_valid;
    assign o_dist_q8      = r_res_dist;
    assign o_no_path      = r_res_np;
    assign o_next_row     = r_res_nr;
    assign o_next_col     = r_res_nc;

`include "grid_wavefront_distance_planner_assert.svh"

    `GWDP_ASSERT_NEXT(a_load_no_result, i_clk, i_rst_n, start && !busy && i_cmd == CMD_LOAD, !o_result_valid, "load produced a result")
    `GWDP_ASSERT_SAME(a_nopath_zero, i_clk, i_rst_n, o_result_valid && o_no_path, o_dist_q8 == '0, "no-path result with nonzero distance")
    `GWDP_ASSERT_NEXT(a_cfg_invalidates, i_clk, i_rst_n, i_cfg_valid && i_cfg_index == CFG_ROWS, !r_cache_valid, "register write kept the goal cache")
    `GWDP_ASSERT_SAME(a_result_when_idle, i_clk, i_rst_n, o_result_valid, !busy, "result shown while busy")

endmodule
`default_nettype wire
